[rtl/core/looped_event_clip_scheduler_top_defines.svh]
// ----------------------------------------------------------------------------
// looped_event_clip_scheduler_top_defines
// Assertion macros shared by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef LOOPED_EVENT_CLIP_SCHEDULER_TOP_DEFINES_SVH
`define LOOPED_EVENT_CLIP_SCHEDULER_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define LECS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check an implication on every rising clock edge outside reset.
`define LECS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/core/lecs_pkg.sv]
// ----------------------------------------------------------------------------
// lecs_pkg
// Types and constants of the looping clip event scheduler.
// ----------------------------------------------------------------------------
package lecs_pkg;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_CLEAR  = 2'd1;
	localparam logic [1:0] OP_BLOCK  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic CFG_CLIP_LENGTH = 1'b0;
	localparam logic CFG_SAMPLE_RATE = 1'b1;

	localparam int DIV_NW    = 64;
	localparam int DIV_DW    = 48;
	localparam int DIV_CNT_W = 7;
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 7'd64;

	localparam logic [17:0] SAMPLE_RATE_RST = 18'd48000;
	localparam logic [5:0]  SECONDS_PER_MIN = 6'd60;
	localparam logic [11:0] OFFSET_MAX      = 12'd4095;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] event_time;
		logic [1:0]  event_size;
		logic [7:0]  event_byte0;
		logic [7:0]  event_byte1;
		logic [7:0]  event_byte2;
		logic [47:0] project_time;
		logic [31:0] tempo;
		logic [12:0] frame_count;
		logic        playing;
	} in_item_t;

	typedef struct packed {
		logic [11:0] frame_offset;
		logic [1:0]  out_size;
		logic [7:0]  out_byte0;
		logic [7:0]  out_byte1;
		logic [7:0]  out_byte2;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [31:0] time_q16;
		logic [1:0]  size;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_BLK_GO,
		S_BLK_W,
		S_MOD_GO,
		S_MOD_W,
		S_SETUP,
		S_RD,
		S_CHK,
		S_OFF_MUL,
		S_OFF_GO,
		S_OFF_W,
		S_PUSH,
		S_FLUSH
	} state_t;

endpackage

[rtl/core/lecs_if.sv]
// ----------------------------------------------------------------------------
// lecs_in_if / lecs_out_if
// Valid/ready channels for command beats and event beats.
// ----------------------------------------------------------------------------
interface lecs_in_if;
	logic                valid;
	logic                ready;
	lecs_pkg::in_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lecs_out_if;
	logic                valid;
	logic                ready;
	lecs_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/lecs_div.sv]
// ----------------------------------------------------------------------------
// lecs_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lecs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lecs_pkg::DIV_NW-1:0]   num,
	input  logic [lecs_pkg::DIV_DW-1:0]   den,
	output logic                          done,
	output logic [lecs_pkg::DIV_NW-1:0]   quo,
	output logic [lecs_pkg::DIV_DW-1:0]   rem
);
	logic [lecs_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [lecs_pkg::DIV_NW-1:0]    n_q;
	logic [lecs_pkg::DIV_DW-1:0]    r_q;
	logic [lecs_pkg::DIV_DW-1:0]    den_q;
	logic                           done_q;
	logic [lecs_pkg::DIV_DW:0]      cand;
	logic                           ge;

	assign cand = {r_q, n_q[lecs_pkg::DIV_NW-1]};
	assign ge   = cand >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= lecs_pkg::DIV_STEPS;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			r_q   <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			// shift in the next numerator bit, subtract when it fits
			n_q <= {n_q[lecs_pkg::DIV_NW-2:0], ge};
			r_q <= ge ? lecs_pkg::DIV_DW'(cand - {1'b0, den_q})
			          : cand[lecs_pkg::DIV_DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = n_q;
	assign rem  = r_q;
endmodule

[rtl/core/looped_event_clip_scheduler_top.sv]
// Append and clear leave the sequencer idle, ready to accept the next command beat.
// An audio block first runs its setup, with up to two divisions on the shared divider (block
// length, skipped when its divisor is zero, and the clip position), then scans the table
// entry by entry with one offset division per emitted event; a wrapping window scans
// the table twice. Reset clears the event count, the clip length and all control state and
// sets the sample rate to 48000; the event table itself is not cleared.
// ----------------------------------------------------------------------------
// looped_event_clip_scheduler_top
// Looping clip event table with a sequencer that schedules one audio block.
// ----------------------------------------------------------------------------
`include "looped_event_clip_scheduler_top_defines.svh"

module looped_event_clip_scheduler_top #(
	parameter int EVENTS  = 256,
	parameter int MAX_OUT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_data,
	lecs_in_if.sink     in_ch,
	lecs_out_if.source  out_ch
);
	localparam int AW = (EVENTS > 1) ? $clog2(EVENTS) : 1;
	localparam int CW = $clog2(EVENTS + 1);
	localparam int OW = $clog2(MAX_OUT + 1);

	lecs_pkg::state_t    state_q, state_d;
	lecs_pkg::entry_t    mem [EVENTS];
	lecs_pkg::entry_t    rd_q;
	lecs_pkg::out_item_t out_q, held_q, new_item, held_last;

	logic [31:0] clip_len_q;
	logic [17:0] srate_q;
	logic [CW-1:0] count_q, idx_q;
	logic [OW-1:0] nout_q;
	logic [47:0] ptime_q;
	logic [31:0] tempo_q;
	logic [12:0] frames_q;
	logic [44:0] num_q;
	logic [23:0] den_q;
	logic [44:0] blk_q;
	logic [31:0] start_q;
	logic [45:0] end_q;
	logic        wrap_q, pass_q;
	logic [45:0] d_q;
	logic [58:0] prod_q;
	logic [11:0] off_q;
	logic        out_v_q, held_v_q;

	logic        in_acc, out_acc, out_free;
	logic        div_start, div_done;
	logic [lecs_pkg::DIV_NW-1:0] div_num, div_quo;
	logic [lecs_pkg::DIV_DW-1:0] div_den, div_rem;
	logic        scan_end, hit, mem_rd, cap_hit;
	logic [45:0] lim0;
	logic [32:0] beat;

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign out_acc  = out_v_q && out_ch.ready;
	assign out_free = !out_v_q;
	assign scan_end = idx_q == count_q;
	assign cap_hit  = (nout_q + 1'b1) == OW'(MAX_OUT);

	assign lim0 = wrap_q ? {14'd0, clip_len_q} : end_q;
	assign hit  = pass_q ? ({14'd0, rd_q.time_q16} < 46'(end_q - {14'd0, clip_len_q}))
	                     : (rd_q.time_q16 >= start_q && {14'd0, rd_q.time_q16} < lim0);
	assign beat = pass_q ? 33'({1'b0, clip_len_q} + {1'b0, rd_q.time_q16})
	                     : {1'b0, rd_q.time_q16};

	assign new_item = '{frame_offset: off_q, out_size: rd_q.size, out_byte0: rd_q.b0,
	                    out_byte1: rd_q.b1, out_byte2: rd_q.b2, last: 1'b0};

	// mark the final beat of the block
	always_comb begin
		held_last      = held_q;
		held_last.last = 1'b1;
	end

	// divider operands by phase
	always_comb begin
		unique case (state_q)
			lecs_pkg::S_BLK_GO: begin
				div_num = {19'd0, num_q};
				div_den = {24'd0, den_q};
			end
			lecs_pkg::S_MOD_GO: begin
				div_num = {16'd0, ptime_q};
				div_den = {16'd0, clip_len_q};
			end
			default: begin
				div_num = {5'd0, prod_q};
				div_den = {3'd0, blk_q};
			end
		endcase
	end

	lecs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo), .rem(div_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lecs_pkg::S_IDLE: begin
				if (in_acc && in_ch.data.opcode == lecs_pkg::OP_BLOCK && in_ch.data.playing
				    && clip_len_q != '0 && count_q != '0) begin
					state_d = lecs_pkg::S_PREP;
				end
			end
			lecs_pkg::S_PREP:   state_d = lecs_pkg::S_BLK_GO;
			lecs_pkg::S_BLK_GO: state_d = (den_q == '0) ? lecs_pkg::S_MOD_GO : lecs_pkg::S_BLK_W;
			lecs_pkg::S_BLK_W:  if (div_done) state_d = lecs_pkg::S_MOD_GO;
			lecs_pkg::S_MOD_GO: state_d = lecs_pkg::S_MOD_W;
			lecs_pkg::S_MOD_W:  if (div_done) state_d = lecs_pkg::S_SETUP;
			lecs_pkg::S_SETUP:  state_d = lecs_pkg::S_RD;
			lecs_pkg::S_RD: begin
				if (!scan_end) begin
					state_d = lecs_pkg::S_CHK;
				end else if (pass_q || !wrap_q) begin
					state_d = lecs_pkg::S_FLUSH;
				end
			end
			lecs_pkg::S_CHK:     state_d = hit ? lecs_pkg::S_OFF_MUL : lecs_pkg::S_RD;
			lecs_pkg::S_OFF_MUL: state_d = lecs_pkg::S_OFF_GO;
			lecs_pkg::S_OFF_GO:  state_d = lecs_pkg::S_OFF_W;
			lecs_pkg::S_OFF_W:   if (div_done) state_d = lecs_pkg::S_PUSH;
			lecs_pkg::S_PUSH: begin
				if (!held_v_q || out_free) begin
					state_d = cap_hit ? lecs_pkg::S_FLUSH : lecs_pkg::S_RD;
				end
			end
			lecs_pkg::S_FLUSH: begin
				if (!held_v_q || out_free) state_d = lecs_pkg::S_IDLE;
			end
			default: state_d = lecs_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		div_start   = 1'b0;
		mem_rd      = 1'b0;
		in_ch.ready = 1'b0;
		unique case (state_q)
			lecs_pkg::S_IDLE:   in_ch.ready = 1'b1;
			lecs_pkg::S_BLK_GO: div_start = den_q != '0;
			lecs_pkg::S_MOD_GO: div_start = 1'b1;
			lecs_pkg::S_OFF_GO: div_start = 1'b1;
			lecs_pkg::S_RD:     mem_rd = !scan_end;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lecs_pkg::S_IDLE;
			clip_len_q <= '0;
			srate_q    <= lecs_pkg::SAMPLE_RATE_RST;
			count_q    <= '0;
			idx_q      <= '0;
			nout_q     <= '0;
			pass_q     <= 1'b0;
			out_v_q    <= 1'b0;
			held_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_idx)
					lecs_pkg::CFG_CLIP_LENGTH: clip_len_q <= cfg_data;
					lecs_pkg::CFG_SAMPLE_RATE: srate_q <= cfg_data[17:0];
				endcase
			end
			if (out_acc) out_v_q <= 1'b0;
			if (in_acc) begin
				if (in_ch.data.opcode == lecs_pkg::OP_APPEND && count_q != CW'(EVENTS)) begin
					count_q <= count_q + 1'b1;
				end else if (in_ch.data.opcode == lecs_pkg::OP_CLEAR) begin
					count_q <= '0;
				end
			end
			unique case (state_q)
				lecs_pkg::S_SETUP: begin
					idx_q    <= '0;
					nout_q   <= '0;
					pass_q   <= 1'b0;
					held_v_q <= 1'b0;
				end
				lecs_pkg::S_RD: begin
					// second pass over the table after the clip end
					if (scan_end && !pass_q && wrap_q) begin
						pass_q <= 1'b1;
						idx_q  <= '0;
					end
				end
				lecs_pkg::S_CHK: idx_q <= idx_q + 1'b1;
				lecs_pkg::S_PUSH: begin
					if (!held_v_q || out_free) begin
						if (held_v_q) out_v_q <= 1'b1;
						held_v_q <= 1'b1;
						nout_q   <= nout_q + 1'b1;
					end
				end
				lecs_pkg::S_FLUSH: begin
					if (held_v_q && out_free) begin
						out_v_q  <= 1'b1;
						held_v_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ptime_q  <= in_ch.data.project_time;
			tempo_q  <= in_ch.data.tempo;
			frames_q <= in_ch.data.frame_count;
		end
		unique case (state_q)
			lecs_pkg::S_PREP: begin
				num_q <= 45'(tempo_q * frames_q);
				den_q <= 24'(srate_q * lecs_pkg::SECONDS_PER_MIN);
			end
			lecs_pkg::S_BLK_GO: if (den_q == '0) blk_q <= '0;
			lecs_pkg::S_BLK_W:  if (div_done) blk_q <= div_quo[44:0];
			lecs_pkg::S_MOD_W:  if (div_done) start_q <= div_rem[31:0];
			lecs_pkg::S_SETUP: begin
				end_q  <= 46'({14'd0, start_q} + {1'b0, blk_q});
				wrap_q <= 46'({14'd0, start_q} + {1'b0, blk_q}) >= {14'd0, clip_len_q};
			end
			lecs_pkg::S_CHK:     d_q <= 46'({13'd0, beat} - {14'd0, start_q});
			lecs_pkg::S_OFF_MUL: prod_q <= 59'(d_q * frames_q);
			lecs_pkg::S_OFF_W: begin
				if (div_done) begin
					off_q <= (div_quo[lecs_pkg::DIV_NW-1:12] != '0) ? lecs_pkg::OFFSET_MAX
					                                                 : div_quo[11:0];
				end
			end
			lecs_pkg::S_PUSH: begin
				if (!held_v_q || out_free) begin
					if (held_v_q) out_q <= held_q;
					held_q <= new_item;
				end
			end
			lecs_pkg::S_FLUSH: begin
				if (held_v_q && out_free) out_q <= held_last;
			end
			default: ;
		endcase
	end

	// event table
	always_ff @(posedge clk) begin
		if (in_acc && in_ch.data.opcode == lecs_pkg::OP_APPEND && count_q != CW'(EVENTS)) begin
			mem[count_q[AW-1:0]] <= '{time_q16: in_ch.data.event_time,
			                          size: in_ch.data.event_size,
			                          b0: in_ch.data.event_byte0,
			                          b1: in_ch.data.event_byte1,
			                          b2: in_ch.data.event_byte2};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_rd) rd_q <= mem[idx_q[AW-1:0]];
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;

	`LECS_ASSERT(a_nout_cap, nout_q <= OW'(MAX_OUT), "more events than the block limit")
	`LECS_ASSERT(a_count_cap, count_q <= CW'(EVENTS), "event count beyond table depth")
	`LECS_ASSERT_IMP(a_div_done_wait, div_done,
		state_q == lecs_pkg::S_BLK_W || state_q == lecs_pkg::S_MOD_W ||
		state_q == lecs_pkg::S_OFF_W, "divider finished outside a wait state")
	`LECS_ASSERT_IMP(a_off_range, div_done && state_q == lecs_pkg::S_OFF_W,
		div_quo < {51'd0, frames_q}, "frame offset not below frame count")
endmodule

[sim/lecs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lecs_checker
// Watches the command and event channels, schedules the expected event beats
// of each audio block from its own copy of the event table and compares them.
// ----------------------------------------------------------------------------
module lecs_checker #(
	parameter int EVENTS  = 256,
	parameter int MAX_OUT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  lecs_pkg::in_item_t  in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  lecs_pkg::out_item_t out_data,
	output int          fail_count,
	output int          pending
);
	lecs_pkg::entry_t    table_q[EVENTS];
	int                  entry_cnt;
	logic [31:0]         clip_len;
	logic [17:0]         rate;
	lecs_pkg::out_item_t sched_q[$];

	assign pending = sched_q.size();

	task automatic put_beat(input lecs_pkg::entry_t e, input logic [63:0] beat,
			input logic [63:0] start, input logic [63:0] beats, input logic [63:0] frames,
			inout int n);
		lecs_pkg::out_item_t o;
		logic [63:0] off;
		off = '0;
		if (n >= MAX_OUT) return;
		if (beats > 0 && beat >= start) begin
			off = ((beat - start) * frames) / beats;
			if (frames > 0 && off > frames - 1) off = frames - 1;
		end
		if (off > 4095) off = 64'd4095;
		o.frame_offset = off[11:0];
		o.out_size = e.size;
		o.out_byte0 = e.b0;
		o.out_byte1 = e.b1;
		o.out_byte2 = e.b2;
		o.last = 1'b0;
		sched_q.push_back(o);
		n++;
	endtask

	task automatic schedule_block(input lecs_pkg::in_item_t it);
		logic [63:0] len, frames, denom, beats, start, stop, t;
		int n;
		n = 0;
		len = {32'd0, clip_len};
		if (!it.playing || len == 0 || entry_cnt == 0) return;
		frames = {51'd0, it.frame_count};
		denom = {46'd0, rate} * 64'd60;
		beats = denom != 0 ? ({32'd0, it.tempo} * frames) / denom : 64'd0;
		start = {16'd0, it.project_time} % len;
		stop = start + beats;
		if (stop < len) begin
			for (int i = 0; i < entry_cnt; i++) begin
				t = {32'd0, table_q[i].time_q16};
				if (t >= start && t < stop) put_beat(table_q[i], t, start, beats, frames, n);
			end
		end else begin
			for (int i = 0; i < entry_cnt; i++) begin
				t = {32'd0, table_q[i].time_q16};
				if (t >= start && t < len) put_beat(table_q[i], t, start, beats, frames, n);
			end
			for (int i = 0; i < entry_cnt; i++) begin
				t = {32'd0, table_q[i].time_q16};
				if (t < stop - len) put_beat(table_q[i], len + t, start, beats, frames, n);
			end
		end
		if (n > 0) sched_q[sched_q.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lecs_pkg::out_item_t exp_beat;
		if (!arst_n) begin
			entry_cnt <= 0;
			clip_len <= '0;
			rate <= lecs_pkg::SAMPLE_RATE_RST;
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == lecs_pkg::CFG_CLIP_LENGTH) clip_len <= cfg_data;
				else rate <= cfg_data[17:0];
			end
			if (in_valid && in_ready) begin
				case (in_data.opcode)
					lecs_pkg::OP_APPEND: begin
						if (entry_cnt < EVENTS) begin
							table_q[entry_cnt] = '{in_data.event_time, in_data.event_size,
								in_data.event_byte0, in_data.event_byte1, in_data.event_byte2};
							entry_cnt <= entry_cnt + 1;
						end
					end
					lecs_pkg::OP_CLEAR: entry_cnt <= 0;
					lecs_pkg::OP_BLOCK: schedule_block(in_data);
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (sched_q.size() == 0) begin
					$display("%0t: unexpected event beat %p", $time, out_data);
					fail_count <= fail_count + 1;
				end else begin
					exp_beat = sched_q.pop_front();
					if (exp_beat !== out_data) begin
						$display("%0t: mismatch expected %p actual %p", $time, exp_beat, out_data);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

[sim/tb_looped_event_clip_scheduler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_looped_event_clip_scheduler_top
// Loads clip events, runs audio blocks under several clip lengths and sample
// rates with random gaps and stalls; the checker compares every event beat.
// ----------------------------------------------------------------------------
module tb_looped_event_clip_scheduler_top;
	localparam int WATCHDOG = 200000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_idx;
	logic [31:0] cfg_data;
	int          fail_count;
	int          pending;
	int          quiet_cycles;
	logic        drain_stall;
	int          stall_left;
	logic [31:0] cur_len;

	lecs_in_if  in_ch();
	lecs_out_if out_ch();

	looped_event_clip_scheduler_top u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	lecs_checker u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_data(in_ch.data), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_data(out_ch.data), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Draw a fresh stall per event beat, with calm stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left <= 0;
		end else if (drain_stall && stall_left == 0 && !(out_ch.valid && out_ch.ready)) begin
			out_ch.ready <= 1'b1;
		end else if (out_ch.valid && out_ch.ready) begin
			if ($urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b1;
			end else begin
				stall_left <= $urandom_range(0, 16);
				out_ch.ready <= 1'b0;
			end
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic lecs_pkg::in_item_t rand_item();
		logic [159:0] r;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom};
		return r[$bits(lecs_pkg::in_item_t)-1:0];
	endfunction

	// Hold valid across back-to-back beats; drop it only for a gap.
	task automatic send(input lecs_pkg::in_item_t it);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.data <= it;
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic append(input logic [31:0] t);
		lecs_pkg::in_item_t it;
		it = '0;
		it.opcode = lecs_pkg::OP_APPEND;
		it.event_time = t;
		it.event_size = 2'($urandom);
		it.event_byte0 = 8'($urandom);
		it.event_byte1 = 8'($urandom);
		it.event_byte2 = 8'($urandom);
		send(it);
	endtask

	task automatic run_block(input logic [47:0] pt, input logic [31:0] tmp,
			input logic [12:0] fc, input logic play);
		lecs_pkg::in_item_t it;
		it = rand_item();
		it.opcode = lecs_pkg::OP_BLOCK;
		it.project_time = pt;
		it.tempo = tmp;
		it.frame_count = fc;
		it.playing = play;
		send(it);
	endtask

	task automatic clear_table();
		lecs_pkg::in_item_t it;
		it = rand_item();
		it.opcode = lecs_pkg::OP_CLEAR;
		send(it);
	endtask

	task automatic write_cfg(input logic idx, input logic [31:0] val);
		in_ch.valid <= 1'b0;
		drain_stall <= 1'b1;
		while (pending != 0) @(posedge clk);
		// the last block may still be scanning without further beats
		repeat (2000) @(posedge clk);
		drain_stall <= 1'b0;
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lecs_pkg::CFG_CLIP_LENGTH) cur_len = val;
	endtask

	task automatic random_phase(input int n);
		lecs_pkg::in_item_t noise;
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				append((cur_len != 0 && $urandom_range(0, 3) != 0) ?
					$urandom_range(0, cur_len - 1) : $urandom);
			end else if (r < 85) begin
				run_block(48'({$urandom, $urandom}), $urandom_range(0, 3) == 0 ? $urandom :
					$urandom_range(60 << 16, 300 << 16),
					$urandom_range(0, 7) == 0 ? 13'($urandom) : 13'($urandom_range(1, 4096)),
					$urandom_range(0, 9) != 0);
			end else if (r < 90) begin
				clear_table();
			end else begin
				noise = rand_item();
				noise.opcode = lecs_pkg::OP_UNUSED;
				send(noise);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = 1'b0;
		cfg_data = '0;
		drain_stall = 1'b0;
		quiet_cycles = 0;
		cur_len = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: skipped blocks, extremes, wrap, table fill and overflow
		run_block(48'd0, 32'd120 << 16, 13'd256, 1'b1);
		write_cfg(lecs_pkg::CFG_CLIP_LENGTH, 32'd4 << 16);
		run_block(48'd0, 32'd120 << 16, 13'd256, 1'b1);
		append(32'd0);
		append(32'h0001_8000);
		append(32'h0003_FFFF);
		append(32'hFFFF_FFFF);
		run_block(48'd0, 32'd120 << 16, 13'd4096, 1'b0);
		run_block(48'h0000_0003_C000, 32'hFFFF_FFFF, 13'd4096, 1'b1);
		run_block(48'hFFFF_FFFF_FFFF, 32'd120 << 16, 13'h1FFF, 1'b1);
		run_block(48'd0, 32'd0, 13'd512, 1'b1);
		run_block(48'd0, 32'd120 << 16, 13'd0, 1'b1);
		write_cfg(lecs_pkg::CFG_SAMPLE_RATE, 32'd0);
		run_block(48'd0, 32'd120 << 16, 13'd512, 1'b1);
		write_cfg(lecs_pkg::CFG_SAMPLE_RATE, 32'd1);
		run_block(48'h0000_0002_0000, 32'hFFFF_FFFF, 13'd4096, 1'b1);
		for (int k = 0; k < 260; k++) append(k[0] ? 32'd100 : 32'd0);
		run_block(48'd0, 32'd120 << 16, 13'd4096, 1'b1);
		clear_table();
		run_block(48'd0, 32'd120 << 16, 13'd4096, 1'b1);

		write_cfg(lecs_pkg::CFG_SAMPLE_RATE, 32'd48000);
		write_cfg(lecs_pkg::CFG_CLIP_LENGTH, 32'd2 << 16);
		random_phase(40);
		write_cfg(lecs_pkg::CFG_SAMPLE_RATE, 32'h3FFFF);
		write_cfg(lecs_pkg::CFG_CLIP_LENGTH, 32'hFFFF_FFFF);
		random_phase(30);
		write_cfg(lecs_pkg::CFG_SAMPLE_RATE, 32'd8000);
		write_cfg(lecs_pkg::CFG_CLIP_LENGTH, 32'd1);
		random_phase(25);
		write_cfg(lecs_pkg::CFG_SAMPLE_RATE, 32'd44100);
		write_cfg(lecs_pkg::CFG_CLIP_LENGTH, 32'h0000_8000);
		random_phase(35);

		in_ch.valid <= 1'b0;
		drain_stall <= 1'b1;
		while (pending != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

[looped_event_clip_scheduler_top.f]
+incdir+rtl/core
rtl/core/lecs_pkg.sv
rtl/core/lecs_if.sv
rtl/core/lecs_div.sv
rtl/core/looped_event_clip_scheduler_top.sv
sim/lecs_checker.sv
sim/tb_looped_event_clip_scheduler_top.sv
